### rtl/ltfr_pkg.sv
// Package for the length-trailed frame receiver.
// Holds the transaction structs, the sequencer state type and the shared constants.
// No dependencies.
package ltfr_pkg;

   // Default receive buffer depth and the capture store depth
   localparam int BUFFER_DEPTH_DEF = 512;
   localparam int CAP_DEPTH        = 256;

   // Register reset values
   localparam logic [7:0] HEADER_RESET  = 8'd193;
   localparam logic [7:0] MIN_LEN_RESET = 8'd4;

   // Configuration register indexes
   localparam logic CSR_HEADER_VALUE     = 1'b0;
   localparam logic CSR_MIN_FRAME_LENGTH = 1'b1;

   // Request function codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic       frame_done;
      logic [7:0] frame_length;
      logic [7:0] read_data;
   } rsp_type;

   // Control from the sequencer to the checksum/compare unit
   typedef struct packed {
      logic       clear;  // start a new scan
      logic       en;     // a buffer byte is present on the read data
      logic [7:0] j;      // frame offset of that byte
      logic [7:0] len;    // length byte under test
   } chk_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAP_READ,
      ST_LEN_CHECK,
      ST_SCAN,
      ST_EVAL,
      ST_COPY,
      ST_RESPOND
   } state_type;

endpackage

### rtl/ltfr_rx_buf.sv
// Receive buffer: linear byte memory, one write port and one registered read port.
// Depends on nothing beyond its parameters.
module ltfr_rx_buf #(
   parameter int DEPTH = 512,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write received bytes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ltfr_cap_store.sv
// Capture store: 256-byte memory holding the last good frame, with per-entry
// valid bits so that unwritten entries read as zero after reset. Uses ltfr_pkg.
module ltfr_cap_store
   import ltfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  logic [7:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0]           mem [CAP_DEPTH];
   logic [CAP_DEPTH-1:0] vld_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_vld_ff;

   // Write frame bytes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Mark written entries, clear all at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read with its valid bit
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : 8'd0;

endmodule

### rtl/ltfr_check_unit.sv
// Frame check unit: one 8-bit accumulator and comparators fed one buffer byte a cycle.
// Uses ltfr_pkg for the control struct.
module ltfr_check_unit
   import ltfr_pkg::*;
(
   input  logic        clock,
   input  chk_ctl_type ctl,
   input  logic [7:0]  rd_data,
   input  logic [7:0]  header,
   output logic        pass
);

   logic [7:0] b0_ff;      // byte at frame offset 0
   logic [7:0] b1_ff;      // byte at frame offset 1
   logic [7:0] before_ff;  // byte before the length byte
   logic [7:0] sum_ff;     // running checksum without offset 0
   logic       in_body;

   // Offsets 2 .. len-3 enter the checksum
   assign in_body = (ctl.j >= 8'd2) && ({1'b0, ctl.j} + 9'd2 < {1'b0, ctl.len});

   // Pick up the fixed-offset bytes and accumulate the body
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         sum_ff <= ctl.len;
      end else if (ctl.en) begin
         if (ctl.j == 8'd0) begin
            b0_ff <= rd_data;
         end
         if (ctl.j == 8'd1) begin
            b1_ff <= rd_data;
         end
         if (ctl.j == ctl.len - 8'd2) begin
            before_ff <= rd_data;
         end
         if (in_body) begin
            sum_ff <= sum_ff + rd_data;
         end
      end
   end

   assign pass = (b0_ff == header) && (b1_ff == before_ff) &&
                 (8'(b0_ff + sum_ff) == before_ff);

endmodule

### rtl/length_trailed_frame_receiver.sv
// Length-trailed frame receiver top level: sequencer, index and length registers.
// Uses ltfr_pkg, ltfr_rx_buf, ltfr_cap_store and ltfr_check_unit.
//
// One transaction at a time. A read passes through ST_CAP_READ and ST_RESPOND
// before its response is valid. A push whose byte L fails the length tests goes
// from ST_LEN_CHECK to ST_RESPOND; one that passes them is scanned through the
// receive buffer's single read port and answers after ST_EVAL if the frame check
// fails. A good frame is then copied through that same port into the capture
// store before ST_RESPOND. req_ready is high only while the sequencer is idle; a
// finished response waits in the output register. The capture store reads as
// zero after reset without a clearing pass.
module length_trailed_frame_receiver
   import ltfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   // configuration port
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int IW = $clog2(BUFFER_DEPTH);

   state_type   state_ff, state_in;

   logic [IW-1:0] wr_idx_ff;
   logic [7:0]    cap_len_ff;
   logic [7:0]    header_ff;
   logic [7:0]    min_len_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [7:0]    len_ff;
   logic [IW-1:0] start_ff;
   logic [7:0]    k_ff;
   logic          res_done_ff;
   logic [7:0]    res_data_ff;

   logic          req_acc;
   logic          len_ok;
   logic [IW:0]   idx_p1;
   logic [IW:0]   len_ext;
   logic [IW-1:0] idx_next;
   logic          k_last;
   logic          pass;
   logic [7:0]    buf_rd_data;
   logic [7:0]    cap_rd_data;
   chk_ctl_type   chk_ctl;

   // sequencer outputs
   logic buf_we, buf_re, cap_we, cap_re;
   logic push_start, read_start, len_load;
   logic k_inc, k_clear, idx_adv, frame_take, cap_res, rsp_load;

   assign req_acc = req_valid && req_ready;

   // Length tests and frame start
   assign idx_p1  = {1'b0, wr_idx_ff} + (IW+1)'(1);
   assign len_ext = (IW+1)'(len_ff);
   assign len_ok  = (len_ff >= 8'd2) && (len_ff >= min_len_ff) && (len_ext <= idx_p1);
   assign idx_next = (wr_idx_ff == IW'(BUFFER_DEPTH - 1)) ? '0 : wr_idx_ff + IW'(1);
   assign k_last  = (k_ff == len_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_data.func == FUNC_READ) ? ST_CAP_READ : ST_LEN_CHECK;
            end
         end
         ST_CAP_READ:  state_in = ST_RESPOND;
         ST_LEN_CHECK: state_in = len_ok ? ST_SCAN : ST_RESPOND;
         ST_SCAN: begin
            if (k_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: state_in = pass ? ST_COPY : ST_RESPOND;
         ST_COPY: begin
            if (k_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      buf_we     = 1'b0;
      buf_re     = 1'b0;
      cap_we     = 1'b0;
      cap_re     = 1'b0;
      push_start = 1'b0;
      read_start = 1'b0;
      len_load   = 1'b0;
      k_inc      = 1'b0;
      k_clear    = 1'b0;
      idx_adv    = 1'b0;
      frame_take = 1'b0;
      cap_res    = 1'b0;
      rsp_load   = 1'b0;
      chk_ctl    = '{clear: 1'b0, en: 1'b0, j: k_ff - 8'd1, len: len_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.func == FUNC_READ) begin
                  cap_re     = 1'b1;
                  read_start = 1'b1;
               end else begin
                  buf_we     = 1'b1;
                  push_start = 1'b1;
               end
            end
         end
         ST_CAP_READ: cap_res = 1'b1;
         ST_LEN_CHECK: begin
            len_load      = 1'b1;
            k_clear       = 1'b1;
            chk_ctl.clear = 1'b1;
            idx_adv       = !len_ok;
         end
         ST_SCAN: begin
            buf_re     = !k_last;
            chk_ctl.en = (k_ff != 8'd0);
            k_inc      = 1'b1;
         end
         ST_EVAL: begin
            k_clear = 1'b1;
            idx_adv = !pass;
         end
         ST_COPY: begin
            buf_re     = !k_last;
            cap_we     = (k_ff != 8'd0);
            k_inc      = 1'b1;
            frame_take = k_last;
         end
         ST_RESPOND: rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         cap_len_ff   <= 8'd0;
         header_ff    <= HEADER_RESET;
         min_len_ff   <= MIN_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // index: advance on a rejected byte, rewind on a captured frame
         if (frame_take) begin
            wr_idx_ff  <= '0;
            cap_len_ff <= len_ff;
         end else if (idx_adv) begin
            wr_idx_ff <= idx_next;
         end
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEADER_VALUE:     header_ff  <= csr_wdata;
               CSR_MIN_FRAME_LENGTH: min_len_ff <= csr_wdata;
               default: ;
            endcase
         end
         // response handshake
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (push_start) begin
         len_ff      <= req_data.rx_byte;
         res_done_ff <= 1'b0;
         res_data_ff <= 8'd0;
      end
      if (read_start) begin
         res_done_ff <= 1'b0;
      end
      if (len_load) begin
         start_ff <= IW'(idx_p1 - len_ext);
      end
      if (k_clear) begin
         k_ff <= 8'd0;
      end else if (k_inc) begin
         k_ff <= k_ff + 8'd1;
      end
      if (frame_take) begin
         res_done_ff <= 1'b1;
      end
      if (cap_res) begin
         res_data_ff <= cap_rd_data;
      end
      if (rsp_load) begin
         rsp_ff <= '{frame_done: res_done_ff, frame_length: cap_len_ff,
                     read_data: res_data_ff};
      end
   end

   ltfr_rx_buf #(
      .DEPTH(BUFFER_DEPTH)
   ) u_rx_buf (
      .clock  (clock),
      .wr_en  (buf_we),
      .wr_addr(wr_idx_ff),
      .wr_data(req_data.rx_byte),
      .rd_en  (buf_re),
      .rd_addr(start_ff + IW'(k_ff)),
      .rd_data(buf_rd_data)
   );

   ltfr_cap_store u_cap_store (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (cap_we),
      .wr_addr(k_ff - 8'd1),
      .wr_data(buf_rd_data),
      .rd_en  (cap_re),
      .rd_addr(req_data.read_index),
      .rd_data(cap_rd_data)
   );

   ltfr_check_unit u_check (
      .clock  (clock),
      .ctl    (chk_ctl),
      .rd_data(buf_rd_data),
      .header (header_ff),
      .pass   (pass)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/ltfr_checker.sv
// Port-level checker for the length-trailed frame receiver, bound to the top level.
// Uses ltfr_pkg for the transaction structs.
module ltfr_checker
   import ltfr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input rsp_type    rsp_data
);

   // No response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Busy in the cycle after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // Read data only comes with reads, never with a completed frame
   a_done_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_done) |-> (rsp_data.read_data == 8'd0))
      else $error("frame done with read data");

   // A completed frame is at least two bytes long
   a_done_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_done) |-> (rsp_data.frame_length >= 8'd2))
      else $error("frame done with short length");

endmodule

bind length_trailed_frame_receiver ltfr_checker u_ltfr_checker (.*);
